// File: rtl/sync_header_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// sync_header_frame_parser assertion macros
// shared property templates for the frame parser checks
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_FRAME_PARSER_ASSERT_SVH
`define SYNC_HEADER_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHFP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHFP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/shfp_pkg.sv
// ----------------------------------------------------------------------------
// shfp_pkg
// types, codes and reset values shared by the sync header frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shfp_pkg;

	// default payload buffer depth
	localparam int SHFP_BUF_DEPTH = 64;

	// configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHK_CMD_A   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHK_CMD_B   = 8'd3;

	// register reset values
	localparam logic [7:0] RST_SYNC_FIRST  = 8'h55;
	localparam logic [7:0] RST_SYNC_SECOND = 8'hAA;
	localparam logic [7:0] RST_CHK_CMD_A   = 8'h82;
	localparam logic [7:0] RST_CHK_CMD_B   = 8'h83;

	// parser phases
	typedef enum logic [2:0] {
		PH_SYNC1 = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_ADDR  = 3'd3,
		PH_CMD   = 3'd4,
		PH_DATA  = 3'd5,
		PH_CSUM  = 3'd6,
		PH_DONE  = 3'd7
	} phase_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_BUSY   = 2'd0,
		ST_DONE   = 2'd1,
		ST_RESYNC = 2'd2,
		ST_OVFL   = 2'd3
	} status_t;

	// configuration registers
	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] checked_cmd_a;
		logic [7:0] checked_cmd_b;
	} cfg_t;

	// parser state
	typedef struct packed {
		phase_t      phase;
		logic        armed;
		logic [7:0]  byte_count;
		logic [7:0]  length;
		logic [7:0]  address;
		logic [7:0]  command;
		logic        crc_flag;
		logic [15:0] checksum;
		logic [7:0]  restart_total;
	} state_t;

	// per-item result besides the held fields
	typedef struct packed {
		status_t    status;
		logic       data_valid;
		logic [5:0] data_index;
		logic [7:0] data_byte;
	} res_t;

endpackage

// File: rtl/shfp_cfg.sv
// ----------------------------------------------------------------------------
// shfp_cfg
// configuration register file: sync bytes and checksum command codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shfp_cfg import shfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// register write decode, unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first    <= RST_SYNC_FIRST;
			cfg_q.sync_second   <= RST_SYNC_SECOND;
			cfg_q.checked_cmd_a <= RST_CHK_CMD_A;
			cfg_q.checked_cmd_b <= RST_CHK_CMD_B;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYNC_FIRST:  cfg_q.sync_first    <= wr_data;
				REG_SYNC_SECOND: cfg_q.sync_second   <= wr_data;
				REG_CHK_CMD_A:   cfg_q.checked_cmd_a <= wr_data;
				REG_CHK_CMD_B:   cfg_q.checked_cmd_b <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/shfp_step.sv
// ----------------------------------------------------------------------------
// shfp_step
// next-state and result logic for one received byte or clear command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shfp_step import shfp_pkg::*; #(
	parameter int BUF_DEPTH = SHFP_BUF_DEPTH
) (
	input  cfg_t       cfg,
	input  state_t     cur,
	input  logic       clr,
	input  logic [7:0] rx_byte,
	output state_t     nxt,
	output res_t       res
);

	// byte_count at which the payload position reaches the buffer depth
	localparam logic [8:0] OVF_LIM = 9'(BUF_DEPTH + 2);

	logic       resync;
	logic       chk_cmd;
	logic       ovfl;
	logic [7:0] pos;
	logic [7:0] cnt_inc;

	always_comb begin
		resync  = cur.armed && (rx_byte == cfg.sync_second);
		chk_cmd = (rx_byte == cfg.checked_cmd_a) || (rx_byte == cfg.checked_cmd_b);
		pos     = cur.byte_count - 8'd2;
		cnt_inc = cur.byte_count + 8'd1;
		ovfl    = (cur.byte_count < 8'd2) || ({1'b0, cur.byte_count} >= OVF_LIM);
	end

	always_comb begin
		nxt = cur;
		res = '{status: ST_BUSY, data_valid: 1'b0, data_index: 6'd0, data_byte: 8'd0};
		if (clr) begin
			// clear: back to hunting, resync total kept
			nxt.phase      = PH_SYNC1;
			nxt.armed      = 1'b0;
			nxt.byte_count = 8'd0;
			nxt.length     = 8'd0;
			nxt.address    = 8'd0;
			nxt.command    = 8'd0;
			nxt.crc_flag   = 1'b0;
			nxt.checksum   = 16'd0;
		end else begin
			case (cur.phase)
				PH_SYNC1: begin
					if (rx_byte == cfg.sync_first)
						nxt.phase = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (rx_byte == cfg.sync_second) begin
						nxt.phase    = PH_LEN;
						nxt.length   = 8'd0;
						nxt.address  = 8'd0;
						nxt.command  = 8'd0;
						nxt.crc_flag = 1'b0;
						nxt.checksum = 16'd0;
					end else begin
						nxt.phase = PH_SYNC1;
					end
				end
				PH_DONE: ;
				default: begin
					// header watch runs ahead of the phase work
					nxt.armed = !cur.armed && (rx_byte == cfg.sync_first);
					if (resync) begin
						nxt.phase         = PH_LEN;
						nxt.length        = 8'd0;
						nxt.address       = 8'd0;
						nxt.command       = 8'd0;
						nxt.crc_flag      = 1'b0;
						nxt.checksum      = 16'd0;
						nxt.restart_total = cur.restart_total + 8'd1;
						res.status        = ST_RESYNC;
					end else begin
						case (cur.phase)
							PH_LEN: begin
								nxt.length = rx_byte;
								nxt.phase  = PH_ADDR;
							end
							PH_ADDR: begin
								nxt.address = rx_byte;
								nxt.phase   = PH_CMD;
							end
							PH_CMD: begin
								if (chk_cmd)
									nxt.crc_flag = 1'b1;
								nxt.command    = rx_byte;
								nxt.byte_count = 8'd2;
								nxt.phase      = PH_DATA;
							end
							PH_DATA: begin
								if (ovfl) begin
									res.status     = ST_OVFL;
									nxt.phase      = PH_SYNC1;
									nxt.armed      = 1'b0;
									nxt.byte_count = 8'd0;
								end else begin
									res.data_valid = 1'b1;
									res.data_index = pos[5:0];
									res.data_byte  = rx_byte;
									nxt.byte_count = cnt_inc;
									if (!cur.crc_flag && cnt_inc == cur.length) begin
										nxt.byte_count = 8'd0;
										nxt.phase      = PH_DONE;
										res.status     = ST_DONE;
									end else if (cur.crc_flag && cur.length >= 8'd2 &&
										cnt_inc == cur.length - 8'd2) begin
										nxt.byte_count = 8'd0;
										nxt.phase      = PH_CSUM;
									end
								end
							end
							PH_CSUM: begin
								// checksum arrives low byte first
								if (cur.byte_count == 8'd0)
									nxt.checksum = cur.checksum | {8'd0, rx_byte};
								else
									nxt.checksum = cur.checksum | {rx_byte, 8'd0};
								nxt.byte_count = cnt_inc;
								if (cnt_inc >= 8'd2) begin
									nxt.byte_count = 8'd0;
									nxt.phase      = PH_DONE;
									res.status     = ST_DONE;
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

endmodule

// File: rtl/sync_header_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_header_frame_parser
// parses received bytes into sync-header frames and streams payload bytes
// ----------------------------------------------------------------------------
// path: an accepted item passes the input register, then the result register,
//   before its result shows; one item per cycle sustained when out_stall is low
// the single parser state register closes its update loop through the step logic
// reset: asynchronous, clears the pipeline valids, parser state and registers
`timescale 1ns / 1ps

module sync_header_frame_parser import shfp_pkg::*; #(
	parameter int BUF_DEPTH = SHFP_BUF_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [7:0]           rx_byte,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 data_valid,
	output logic [5:0]           data_index,
	output logic [7:0]           data_byte,
	output logic [7:0]           frame_length,
	output logic [7:0]           frame_address,
	output logic [7:0]           frame_command,
	output logic                 checksum_enabled,
	output logic [15:0]          frame_checksum,
	output logic [7:0]           resync_count,
	// configuration write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t       cfg;
	state_t     state_q;
	state_t     state_nxt;
	res_t       res;
	res_t       res_q;
	state_t     held_q;
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	logic       advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	shfp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake between input register and result register
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	// per-item parser logic
	shfp_step #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.clr     (command_s1),
		.rx_byte (rx_byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_SYNC1, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q  <= res;
			held_q <= state_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign data_valid       = res_q.data_valid;
	assign data_index       = res_q.data_index;
	assign data_byte        = res_q.data_byte;
	assign frame_length     = held_q.length;
	assign frame_address    = held_q.address;
	assign frame_command    = held_q.command;
	assign checksum_enabled = held_q.crc_flag;
	assign frame_checksum   = held_q.checksum;
	assign resync_count     = held_q.restart_total;

endmodule

// File: rtl/shfp_checker.sv
// ----------------------------------------------------------------------------
// shfp_checker
// port-level checks on the sync header frame parser results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sync_header_frame_parser_assert.svh"

module shfp_checker import shfp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status,
	input logic                 data_valid,
	input logic [5:0]           data_index,
	input logic [7:0]           data_byte,
	input logic [7:0]           frame_length,
	input logic [7:0]           frame_address,
	input logic [7:0]           frame_command,
	input logic                 checksum_enabled,
	input logic [15:0]          frame_checksum,
	input logic [7:0]           resync_count
);

	// a payload item never carries resync or overflow status
	`SHFP_ASSERT_IMP(a_data_status, out_valid && data_valid,
		status == ST_BUSY || status == ST_DONE, "payload item with resync or overflow status")

	// non-payload items show a zero index and byte
	`SHFP_ASSERT_IMP(a_data_zero, out_valid && !data_valid,
		data_index == 6'd0 && data_byte == 8'd0, "non-payload item with nonzero data")

	// a resync clears every held frame field
	`SHFP_ASSERT_IMP(a_resync_clear, out_valid && status == ST_RESYNC,
		frame_length == 8'd0 && frame_address == 8'd0 && frame_command == 8'd0 &&
		!checksum_enabled && frame_checksum == 16'd0, "held fields not cleared on resync")

	// a stalled result holds
	`SHFP_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(status) && $stable(data_byte) && $stable(resync_count),
		"stalled result changed")

endmodule

bind sync_header_frame_parser shfp_checker u_shfp_checker (.*);

// File: tb/sv/frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_parser_checker
// watches the item, result and register channels of the frame parser, keeps
// its own copy of parser state and registers, and compares every result
// ----------------------------------------------------------------------------

module frame_parser_checker import shfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 command,
	input  logic [7:0]           rx_byte,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic                 data_valid,
	input  logic [5:0]           data_index,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           frame_length,
	input  logic [7:0]           frame_address,
	input  logic [7:0]           frame_command,
	input  logic                 checksum_enabled,
	input  logic [15:0]          frame_checksum,
	input  logic [7:0]           resync_count,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		status_t     status;
		logic        data_valid;
		logic [5:0]  data_index;
		logic [7:0]  data_byte;
		logic [7:0]  length;
		logic [7:0]  address;
		logic [7:0]  command;
		logic        crc_on;
		logic [15:0] checksum;
		logic [7:0]  resyncs;
	} frame_result_t;

	cfg_t          regs;
	state_t        st;
	frame_result_t frame_results_due[$];
	frame_result_t want;

	// wipe the fields of the frame being parsed
	function automatic void clear_held();
		st.length   = '0;
		st.address  = '0;
		st.command  = '0;
		st.crc_flag = 1'b0;
		st.checksum = '0;
	endfunction

	// advance the parser copy by one item and return the result it gives
	function automatic frame_result_t parse_item(input logic clear_req, input logic [7:0] b);
		frame_result_t r;
		logic [7:0]    pos;
		logic          restarted;
		r = '0;
		r.status = ST_BUSY;
		restarted = 1'b0;
		if (clear_req) begin
			st.phase = PH_SYNC1;
			st.armed = 1'b0;
			st.byte_count = '0;
			clear_held();
		end else begin
			case (st.phase)
				PH_SYNC1: begin
					if (b == regs.sync_first)
						st.phase = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (b == regs.sync_second) begin
						clear_held();
						st.phase = PH_LEN;
					end else begin
						st.phase = PH_SYNC1;
					end
				end
				PH_DONE: ;
				default: begin
					// header watch runs ahead of the field handling
					if (!st.armed && b == regs.sync_first) begin
						st.armed = 1'b1;
					end else if (st.armed && b == regs.sync_second) begin
						st.armed = 1'b0;
						clear_held();
						st.phase = PH_LEN;
						st.restart_total = st.restart_total + 8'd1;
						r.status = ST_RESYNC;
						restarted = 1'b1;
					end else begin
						st.armed = 1'b0;
					end
					if (!restarted) begin
						case (st.phase)
							PH_LEN: begin
								st.length = b;
								st.phase = PH_ADDR;
							end
							PH_ADDR: begin
								st.address = b;
								st.phase = PH_CMD;
							end
							PH_CMD: begin
								if (b == regs.checked_cmd_a || b == regs.checked_cmd_b)
									st.crc_flag = 1'b1;
								st.command = b;
								st.byte_count = 8'd2;
								st.phase = PH_DATA;
							end
							PH_DATA: begin
								pos = st.byte_count - 8'd2;
								if (st.byte_count < 8'd2 || pos >= SHFP_BUF_DEPTH) begin
									// payload ran past the buffer, back to hunting
									r.status = ST_OVFL;
									st.phase = PH_SYNC1;
									st.armed = 1'b0;
									st.byte_count = '0;
								end else begin
									r.data_valid = 1'b1;
									r.data_index = pos[5:0];
									r.data_byte = b;
									st.byte_count = st.byte_count + 8'd1;
									if (!st.crc_flag && st.byte_count == st.length) begin
										st.byte_count = '0;
										st.phase = PH_DONE;
										r.status = ST_DONE;
									end else if (st.crc_flag && st.length >= 8'd2 &&
											st.byte_count == st.length - 8'd2) begin
										st.byte_count = '0;
										st.phase = PH_CSUM;
									end
								end
							end
							default: begin
								// checksum, low byte first
								if (st.byte_count == 8'd0)
									st.checksum[7:0] = st.checksum[7:0] | b;
								else
									st.checksum[15:8] = st.checksum[15:8] | b;
								st.byte_count = st.byte_count + 8'd1;
								if (st.byte_count >= 8'd2) begin
									st.byte_count = '0;
									st.phase = PH_DONE;
									r.status = ST_DONE;
								end
							end
						endcase
					end
				end
			endcase
		end
		r.length   = st.length;
		r.address  = st.address;
		r.command  = st.command;
		r.crc_on   = st.crc_flag;
		r.checksum = st.checksum;
		r.resyncs  = st.restart_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] got_val);
		if (got_val !== exp_val) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
		end
	endtask

	// watch the channels on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.sync_first    = RST_SYNC_FIRST;
			regs.sync_second   = RST_SYNC_SECOND;
			regs.checked_cmd_a = RST_CHK_CMD_A;
			regs.checked_cmd_b = RST_CHK_CMD_B;
			st = '0;
			st.phase = PH_SYNC1;
			frame_results_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// results are matched before this edge's item is predicted
			if (out_valid && !out_stall) begin
				if (frame_results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result mismatch, expected none, got status %0d",
							$time, status);
				end else begin
					want = frame_results_due.pop_front();
					check_field("status", want.status, status);
					check_field("data_valid", want.data_valid, data_valid);
					check_field("data_index", want.data_index, data_index);
					check_field("data_byte", want.data_byte, data_byte);
					check_field("frame_length", want.length, frame_length);
					check_field("frame_address", want.address, frame_address);
					check_field("frame_command", want.command, frame_command);
					check_field("checksum_enabled", want.crc_on, checksum_enabled);
					check_field("frame_checksum", want.checksum, frame_checksum);
					check_field("resync_count", want.resyncs, resync_count);
				end
			end
			if (in_valid && !in_stall)
				frame_results_due.push_back(parse_item(command, rx_byte));
			// register writes, unknown indexes do nothing
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SYNC_FIRST:  regs.sync_first = cfg_data;
					REG_SYNC_SECOND: regs.sync_second = cfg_data;
					REG_CHK_CMD_A:   regs.checked_cmd_a = cfg_data;
					REG_CHK_CMD_B:   regs.checked_cmd_b = cfg_data;
					default: ;
				endcase
			end
			outstanding = frame_results_due.size();
		end
	end

endmodule

// File: tb/sv/sync_header_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_header_frame_parser_test
// drives framed byte streams, broken headers, restarts, overflows and clears
// through the parser under several register settings with random gaps and
// output stalls; the checker beside the block predicts and compares results
// ----------------------------------------------------------------------------

module sync_header_frame_parser_test;
	import shfp_pkg::*;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'hFF;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 command;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic                 data_valid;
	logic [5:0]           data_index;
	logic [7:0]           data_byte;
	logic [7:0]           frame_length;
	logic [7:0]           frame_address;
	logic [7:0]           frame_command;
	logic                 checksum_enabled;
	logic [15:0]          frame_checksum;
	logic [7:0]           resync_count;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	int         mismatches;
	int         outstanding;
	int         items_sent = 0;
	int         gap_rate = 0;
	int         stall_rate = 0;
	int         quiet_cycles;
	logic       hold_out = 1'b0;
	logic [7:0] sync_a = RST_SYNC_FIRST;
	logic [7:0] sync_b = RST_SYNC_SECOND;
	logic [7:0] chk_a = RST_CHK_CMD_A;
	logic [7:0] chk_b = RST_CHK_CMD_B;

	sync_header_frame_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.data_valid(data_valid), .data_index(data_index), .data_byte(data_byte),
		.frame_length(frame_length), .frame_address(frame_address),
		.frame_command(frame_command), .checksum_enabled(checksum_enabled),
		.frame_checksum(frame_checksum), .resync_count(resync_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	frame_parser_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.data_valid(data_valid), .data_index(data_index), .data_byte(data_byte),
		.frame_length(frame_length), .frame_address(frame_address),
		.frame_command(frame_command), .checksum_enabled(checksum_enabled),
		.frame_checksum(frame_checksum), .resync_count(resync_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// give up when nothing moves on any channel for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stall bursts and one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item and wait until it is taken, maybe after a gap
	task automatic send_item(input logic clear_req, input logic [7:0] value);
		if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= clear_req;
		rx_byte  <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] value);
		send_item(CMD_BYTE, value);
	endtask

	task automatic send_clear();
		send_item(CMD_CLEAR, 8'($urandom));
	endtask

	task automatic send_header();
		send_byte(sync_a);
		send_byte(sync_b);
	endtask

	// command byte that does or does not select the trailing checksum
	function automatic logic [7:0] pick_command(input logic crc_on);
		logic [7:0] code;
		if (crc_on)
			return $urandom_range(0, 1) ? chk_a : chk_b;
		do code = 8'($urandom); while (code == chk_a || code == chk_b);
		return code;
	endfunction

	// length, address, command, payload and checksum of a well-formed frame;
	// stops before byte number cut, else finishes with stray bytes and a clear
	task automatic send_frame_body(input int cut, input int payload_len, input logic crc_on);
		logic [7:0] cmd_code;
		logic [7:0] len_code;
		int         n;
		int         body_len;
		if (payload_len > 0)
			n = payload_len;
		else if ($urandom_range(0, 15) == 0)
			n = $urandom_range(1, SHFP_BUF_DEPTH);
		else
			n = $urandom_range(1, 8);
		cmd_code = pick_command(crc_on);
		len_code = crc_on ? 8'(n + 4) : 8'(n + 2);
		body_len = n + (crc_on ? 5 : 3);
		for (int i = 0; i < body_len; i++) begin
			if (i == cut)
				return;
			if (i == 0)
				send_byte(len_code);
			else if (i == 2)
				send_byte(cmd_code);
			else
				send_byte(8'($urandom));
		end
		// bytes after a complete frame are ignored
		repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
		send_clear();
	endtask

	// a length the payload can never meet, so the buffer overflows
	task automatic send_overflow_frame();
		logic       crc_on;
		logic       short_len;
		logic [7:0] len_code;
		crc_on = 1'($urandom_range(0, 1));
		short_len = 1'($urandom_range(0, 1));
		if (crc_on)
			len_code = short_len ? 8'($urandom_range(0, 4)) :
				8'($urandom_range(SHFP_BUF_DEPTH + 5, 255));
		else
			len_code = short_len ? 8'($urandom_range(0, 2)) :
				8'($urandom_range(SHFP_BUF_DEPTH + 3, 255));
		send_header();
		send_byte(len_code);
		send_byte(8'($urandom));
		send_byte(pick_command(crc_on));
		repeat (SHFP_BUF_DEPTH + 1) send_byte(8'($urandom));
	endtask

	// mostly good frames, some restarts, overflows, cut frames and noise
	task automatic send_random_frame();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			send_header();
			send_frame_body(-1, 0, 1'($urandom_range(0, 1)));
		end else if (pick < 70) begin
			send_header();
			send_frame_body($urandom_range(0, 9), 0, 1'($urandom_range(0, 1)));
			send_header();
			send_frame_body(-1, 0, 1'($urandom_range(0, 1)));
		end else if (pick < 74) begin
			send_overflow_frame();
		end else if (pick < 86) begin
			send_header();
			send_frame_body($urandom_range(0, 6), 0, 1'($urandom_range(0, 1)));
			send_clear();
		end else begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 5) == 0)
					send_clear();
				else if ($urandom_range(0, 2) == 0)
					send_byte($urandom_range(0, 1) ? sync_a : sync_b);
				else
					send_byte(8'($urandom));
			end
			send_clear();
		end
	endtask

	// stop offering and let every outstanding result come out
	task automatic drain(input int tail);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		case (idx)
			REG_SYNC_FIRST:  sync_a = value;
			REG_SYNC_SECOND: sync_b = value;
			REG_CHK_CMD_A:   chk_a = value;
			REG_CHK_CMD_B:   chk_b = value;
			default: ;
		endcase
	endtask

	// all four registers plus two indexes past the end
	task automatic program_regs(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] cmd_a, input logic [7:0] cmd_b);
		write_reg(REG_UNUSED_FIRST, 8'($urandom));
		write_reg(REG_SYNC_FIRST, first);
		write_reg(REG_SYNC_SECOND, second);
		write_reg(REG_CHK_CMD_A, cmd_a);
		write_reg(REG_CHK_CMD_B, cmd_b);
		write_reg(REG_UNUSED_LAST, 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] pair_code;
		logic [7:0] chk_code;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_BYTE;
		rx_byte   = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_SYNC_FIRST;
		cfg_data  = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames with the reset register values
		gap_rate = 4;
		stall_rate = 4;
		send_clear();
		send_byte(sync_a);
		send_byte(8'h00);
		send_header();
		send_byte(8'h04);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sync_a);
		send_clear();
		// restart in the address byte, then a checksum frame
		send_header();
		send_byte(8'h07);
		send_header();
		send_byte(8'h05);
		send_byte(8'hFF);
		send_byte(chk_b);
		send_byte(8'hA5);
		send_byte(8'h34);
		send_byte(8'h12);
		send_clear();
		drain(4);

		// extreme register values, biggest frames, long output hold-off
		program_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
		gap_rate = 6;
		stall_rate = 6;
		send_header();
		send_frame_body(-1, SHFP_BUF_DEPTH, 1'b0);
		send_header();
		send_frame_body(-1, SHFP_BUF_DEPTH, 1'b1);
		send_overflow_frame();
		repeat (4) send_random_frame();
		hold_out = 1'b1;
		while (items_sent < 500) send_random_frame();
		drain(4);

		// equal sync bytes and equal checksum commands, sender gaps only
		pair_code = 8'($urandom);
		chk_code = 8'($urandom);
		program_regs(pair_code, pair_code, chk_code, chk_code);
		gap_rate = 3;
		stall_rate = 0;
		send_overflow_frame();
		while (items_sent < 850) send_random_frame();
		drain(4);

		// random registers, receiver stalls only
		program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		gap_rate = 0;
		stall_rate = 3;
		while (items_sent < 1150) send_random_frame();
		drain(4);

		// reset values again, full rate on both sides
		program_regs(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_CHK_CMD_A, RST_CHK_CMD_B);
		gap_rate = 0;
		stall_rate = 0;
		while (items_sent < 1400) send_random_frame();
		drain(8);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
